// ===== rtl/lpcc_pkg.sv =====
// Shared types and constants for the longest-path cycle check block.
// Used by lpcc_ctrl, lpcc_dp, longest_path_cycle_check and the testbench.
`default_nettype none
package lpcc_pkg;

    localparam int MAX_VERTICES_DEF = 256;
    localparam int MAX_EDGES_DEF    = 1024;

    localparam int VERT_W   = 9;
    localparam int REWARD_W = 31;
    localparam int COST_W   = 32;
    localparam int DIST_W   = 44;
    localparam int EDGE_W   = 2 * VERT_W + COST_W;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [APB_ADDR_W-1:0] ADDR_VERTEX_COUNT = 3'd0;
    localparam logic [VERT_W-1:0]     VERTEX_COUNT_RST  = 9'd256;

    localparam logic signed [DIST_W-1:0] DIST_INF   = 44'sd5000000000000;
    localparam logic signed [DIST_W-1:0] DIST_FLOOR = {1'b1, {(DIST_W-1){1'b0}}};

    typedef enum logic [3:0] {
        S_LOAD,
        S_MARK_INIT,
        S_MARK_RD,
        S_MARK_CHK,
        S_RLX_INIT,
        S_RLX_RD,
        S_RLX_EDGE,
        S_RLX_DF,
        S_RLX_DT,
        S_FIN_RD,
        S_FIN_WR
    } lpcc_state_t;

    typedef struct packed {
        logic accept;
        logic mark_init;
        logic mark_chk;
        logic pass_restart;
        logic rlx_init;
        logic rlx_edge;
        logic rlx_df;
        logic rlx_dt;
        logic next_round;
        logic set_unb;
        logic fin_rd;
        logic fin_wr;
    } lpcc_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic edge_last;
        logic mark_any;
        logic rlx_unb;
        logic round_last;
        logic out_busy;
    } lpcc_status_t;

endpackage
`default_nettype wire

// ===== rtl/lpcc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lpcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/lpcc_ctrl.sv =====
// Sequencer for loading, reachability marking, relaxation rounds and result.
// Depends on lpcc_pkg.
`default_nettype none
module lpcc_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  last_edge,
    output logic                       in_stall,
    input  wire lpcc_pkg::lpcc_status_t status,
    output lpcc_pkg::lpcc_cmd_t        cmd
);
    import lpcc_pkg::*;

    lpcc_state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_LOAD:
            begin
                // a closing item waits until the previous result is taken
                in_stall   = status.out_busy && last_edge;
                cmd.accept = in_valid && !in_stall;
                if (cmd.accept && last_edge)
                begin
                    state_next = S_MARK_INIT;
                end
            end
            S_MARK_INIT:
            begin
                cmd.mark_init = 1'b1;
                state_next    = status.count_zero ? S_RLX_INIT : S_MARK_RD;
            end
            S_MARK_RD:
            begin
                state_next = S_MARK_CHK;
            end
            S_MARK_CHK:
            begin
                cmd.mark_chk = 1'b1;
                state_next   = S_MARK_RD;
                if (status.edge_last)
                begin
                    if (status.mark_any)
                    begin
                        cmd.pass_restart = 1'b1;
                    end
                    else
                    begin
                        state_next = S_RLX_INIT;
                    end
                end
            end
            S_RLX_INIT:
            begin
                cmd.rlx_init = 1'b1;
                state_next   = status.count_zero ? S_FIN_RD : S_RLX_RD;
            end
            S_RLX_RD:
            begin
                state_next = S_RLX_EDGE;
            end
            S_RLX_EDGE:
            begin
                cmd.rlx_edge = 1'b1;
                state_next   = S_RLX_DF;
            end
            S_RLX_DF:
            begin
                cmd.rlx_df = 1'b1;
                state_next = S_RLX_DT;
            end
            S_RLX_DT:
            begin
                cmd.rlx_dt = 1'b1;
                state_next = S_RLX_RD;
                if (status.rlx_unb)
                begin
                    cmd.set_unb = 1'b1;
                    state_next  = S_FIN_RD;
                end
                else if (status.edge_last)
                begin
                    if (status.round_last)
                    begin
                        state_next = S_FIN_RD;
                    end
                    else
                    begin
                        cmd.next_round = 1'b1;
                    end
                end
            end
            S_FIN_RD:
            begin
                cmd.fin_rd = 1'b1;
                state_next = S_FIN_WR;
            end
            S_FIN_WR:
            begin
                // keep the read address so the data stays valid while waiting
                cmd.fin_rd = 1'b1;
                cmd.fin_wr = !status.out_busy;
                if (!status.out_busy)
                begin
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/lpcc_dp.sv =====
// Datapath: edge store, reach flags, distance store, relaxation and result.
// Depends on lpcc_pkg and lpcc_ram.
`default_nettype none
module lpcc_dp #(
    parameter int MAX_VERTICES = lpcc_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = lpcc_pkg::MAX_EDGES_DEF,
    parameter int NW           = $clog2(MAX_VERTICES + 1)
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire lpcc_pkg::lpcc_cmd_t                    cmd,
    output lpcc_pkg::lpcc_status_t                      status,
    input  wire logic [NW-1:0]                          n_eff,
    input  wire logic [lpcc_pkg::VERT_W-1:0]            from_vertex,
    input  wire logic [lpcc_pkg::VERT_W-1:0]            to_vertex,
    input  wire logic signed [lpcc_pkg::REWARD_W-1:0]   reward,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic signed [lpcc_pkg::DIST_W-1:0]          high_score,
    output logic                                        unbounded,
    output logic                                        edges_dropped
);
    import lpcc_pkg::*;

    localparam int VA = $clog2(MAX_VERTICES);
    localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EW = $clog2(MAX_EDGES + 1);
    localparam int CW = (NW > VERT_W) ? NW : VERT_W;

    logic [EW-1:0] cnt_reg;
    logic          ovf_reg;
    logic [EW-1:0] e_reg;
    logic          changed_reg;
    logic [MAX_VERTICES-1:0] reach_reg;
    logic [MAX_VERTICES-1:0] dvalid_reg;
    logic [NW-1:0] round_reg;
    logic          unb_reg;
    logic          out_valid_reg;
    logic          rdv_reg;

    logic [VA-1:0]              t_reg;
    logic signed [COST_W-1:0]   cost_reg;
    logic                       use_reg;
    logic signed [DIST_W-1:0]   df_reg;

    // edge store
    logic                     er_we;
    logic [EDGE_W-1:0]        er_wdata, er_rdata;
    logic signed [COST_W-1:0] cost_in;

    assign cost_in  = -{{(COST_W-REWARD_W){reward[REWARD_W-1]}}, reward};
    assign er_we    = cmd.accept && (cnt_reg < EW'(MAX_EDGES));
    assign er_wdata = {from_vertex, to_vertex, cost_in};

    lpcc_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES), .AW(EA)) u_edge_ram (
        .clk   (clk),
        .we    (er_we),
        .waddr (cnt_reg[EA-1:0]),
        .wdata (er_wdata),
        .raddr (e_reg[EA-1:0]),
        .rdata (er_rdata)
    );

    // decode the edge just read
    logic [VERT_W-1:0]        ed_from, ed_to;
    logic signed [COST_W-1:0] ed_cost;
    logic [CW-1:0]            f_m1, t_m1, n_m1;
    logic [VA-1:0]            f_idx, t_idx, n_idx;
    logic                     f_ok, t_ok, mark_hit;

    assign ed_from = er_rdata[EDGE_W-1 -: VERT_W];
    assign ed_to   = er_rdata[COST_W+VERT_W-1 -: VERT_W];
    assign ed_cost = er_rdata[COST_W-1:0];
    assign f_m1    = CW'(ed_from) - CW'(1);
    assign t_m1    = CW'(ed_to) - CW'(1);
    assign n_m1    = CW'(n_eff) - CW'(1);
    assign f_idx   = f_m1[VA-1:0];
    assign t_idx   = t_m1[VA-1:0];
    assign n_idx   = n_m1[VA-1:0];
    assign f_ok    = (ed_from != '0) && (CW'(ed_from) <= CW'(n_eff));
    assign t_ok    = (ed_to != '0) && (CW'(ed_to) <= CW'(n_eff));
    assign mark_hit = f_ok && t_ok && reach_reg[t_idx] && !reach_reg[f_idx];

    // distance store, invalid entries read as infinity
    logic                     dr_we;
    logic [VA-1:0]            dr_waddr, dr_raddr;
    logic [DIST_W-1:0]        dr_wdata, dr_rdata;
    logic signed [DIST_W-1:0] dist_rd;

    always_comb
    begin
        priority if (cmd.rlx_edge)
        begin
            dr_raddr = f_idx;
        end
        else if (cmd.rlx_df)
        begin
            dr_raddr = t_reg;
        end
        else if (cmd.fin_rd)
        begin
            dr_raddr = n_idx;
        end
        else
        begin
            dr_raddr = '0;
        end
    end

    lpcc_ram #(.WIDTH(DIST_W), .DEPTH(MAX_VERTICES), .AW(VA)) u_dist_ram (
        .clk   (clk),
        .we    (dr_we),
        .waddr (dr_waddr),
        .wdata (dr_wdata),
        .raddr (dr_raddr),
        .rdata (dr_rdata)
    );

    assign dist_rd = rdv_reg ? signed'(dr_rdata) : DIST_INF;

    // relaxation compare, signed on both sides
    logic signed [DIST_W:0] cand;
    logic                   better, below;

    assign cand   = {df_reg[DIST_W-1], df_reg}
                  + {{(DIST_W+1-COST_W){cost_reg[COST_W-1]}}, cost_reg};
    assign better = use_reg && (df_reg != DIST_INF)
                  && (cand < $signed({dist_rd[DIST_W-1], dist_rd}));
    assign below  = cand < $signed({DIST_FLOOR[DIST_W-1], DIST_FLOOR});

    assign dr_we    = cmd.rlx_init || (cmd.rlx_dt && better && !below);
    assign dr_waddr = cmd.rlx_init ? '0 : t_reg;
    assign dr_wdata = cmd.rlx_init ? '0 : cand[DIST_W-1:0];

    // status to the controller
    assign status.count_zero = (cnt_reg == '0);
    assign status.edge_last  = ((e_reg + EW'(1)) == cnt_reg);
    assign status.mark_any   = changed_reg || mark_hit;
    assign status.round_last = ((round_reg + NW'(1)) == n_eff);
    assign status.rlx_unb    = better && (below || status.round_last);
    assign status.out_busy   = out_valid_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            e_reg         <= '0;
            changed_reg   <= 1'b0;
            reach_reg     <= '0;
            dvalid_reg    <= '0;
            round_reg     <= '0;
            unb_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            rdv_reg       <= 1'b0;
        end
        else
        begin
            rdv_reg <= dvalid_reg[dr_raddr];
            if (cmd.accept)
            begin
                if (er_we)
                begin
                    cnt_reg <= cnt_reg + EW'(1);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.mark_init)
            begin
                reach_reg[n_idx] <= 1'b1;
                e_reg            <= '0;
                changed_reg      <= 1'b0;
            end
            if (cmd.mark_chk)
            begin
                if (mark_hit)
                begin
                    reach_reg[f_idx] <= 1'b1;
                end
                // a pass that changed a flag starts another pass
                if (cmd.pass_restart)
                begin
                    e_reg       <= '0;
                    changed_reg <= 1'b0;
                end
                else
                begin
                    e_reg <= e_reg + EW'(1);
                    if (mark_hit)
                    begin
                        changed_reg <= 1'b1;
                    end
                end
            end
            if (cmd.rlx_init)
            begin
                dvalid_reg[0] <= 1'b1;
                e_reg         <= '0;
                round_reg     <= '0;
            end
            if (cmd.rlx_dt)
            begin
                if (cmd.next_round)
                begin
                    e_reg     <= '0;
                    round_reg <= round_reg + NW'(1);
                end
                else
                begin
                    e_reg <= e_reg + EW'(1);
                end
                if (better && !below)
                begin
                    dvalid_reg[t_reg] <= 1'b1;
                end
            end
            if (cmd.set_unb)
            begin
                unb_reg <= 1'b1;
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.fin_wr)
            begin
                out_valid_reg <= 1'b1;
                cnt_reg       <= '0;
                ovf_reg       <= 1'b0;
                reach_reg     <= '0;
                dvalid_reg    <= '0;
                unb_reg       <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.rlx_edge)
        begin
            t_reg    <= t_idx;
            cost_reg <= ed_cost;
            use_reg  <= f_ok && t_ok && reach_reg[f_idx] && reach_reg[t_idx];
        end
        if (cmd.rlx_df)
        begin
            df_reg <= dist_rd;
        end
        if (cmd.fin_wr)
        begin
            high_score    <= unb_reg ? '0 : -dist_rd;
            unbounded     <= unb_reg;
            edges_dropped <= ovf_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

// ===== rtl/longest_path_cycle_check.sv =====
// Top level of the longest-path cycle check: APB register, controller, datapath.
// Depends on lpcc_pkg, lpcc_ctrl, lpcc_dp and lpcc_ram.
//
// Usage:
//   Edges arrive on the input channel (in_valid / in_stall), one item per edge,
//   with from_vertex, to_vertex, reward and last_edge. Loading takes one item
//   per cycle while in_stall is low. The item with last_edge set closes the
//   graph and starts compute; in_stall stays high until the result is formed.
//   Compute first marks, in repeated passes over the stored edges, the vertices
//   that reach the last vertex; a pass that changes a flag starts another pass.
//   Relaxation then runs at most one round per vertex and stops early when a
//   positive cycle is found. Each relaxation edge visit reads the edge store
//   once and the distance store twice, through one read port each. The result
//   appears on the output channel (out_valid / out_stall) and is held until
//   taken; the stores are cleared as the result is formed, so the next graph
//   may be loaded while the result waits. A closing item is stalled until the
//   previous result has been taken. vertex_count must be written by the user
//   over APB at byte address 0 only while idle; the block does not enforce it.
//   Reset sets vertex_count to 256, empties all stores and drops any result.
`default_nettype none
module longest_path_cycle_check #(
    parameter int MAX_VERTICES = lpcc_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = lpcc_pkg::MAX_EDGES_DEF
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    in_valid,
    output logic                                         in_stall,
    input  wire logic [lpcc_pkg::VERT_W-1:0]             from_vertex,
    input  wire logic [lpcc_pkg::VERT_W-1:0]             to_vertex,
    input  wire logic signed [lpcc_pkg::REWARD_W-1:0]    reward,
    input  wire logic                                    last_edge,
    output logic                                         out_valid,
    input  wire logic                                    out_stall,
    output logic signed [lpcc_pkg::DIST_W-1:0]           high_score,
    output logic                                         unbounded,
    output logic                                         edges_dropped,
    input  wire logic                                    psel,
    input  wire logic                                    penable,
    input  wire logic                                    pwrite,
    input  wire logic [lpcc_pkg::APB_ADDR_W-1:0]         paddr,
    input  wire logic [lpcc_pkg::APB_DATA_W-1:0]         pwdata,
    output logic      [lpcc_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                         pready
);
    import lpcc_pkg::*;

    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int CW = (NW > VERT_W) ? NW : VERT_W;

    // configuration register
    logic [VERT_W-1:0] vcount_reg;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_VERTEX_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= VERTEX_COUNT_RST;
        end
        else if (cfg_wr)
        begin
            vcount_reg <= pwdata[VERT_W-1:0];
        end
    end

    assign prdata = (paddr == ADDR_VERTEX_COUNT)
                  ? {{(APB_DATA_W-VERT_W){1'b0}}, vcount_reg} : '0;

    // effective vertex count, clamped to 1..MAX_VERTICES
    logic [CW-1:0] vc_ext;
    logic [NW-1:0] n_eff;

    assign vc_ext = CW'(vcount_reg);
    always_comb
    begin
        priority if (vcount_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (vc_ext > CW'(MAX_VERTICES))
        begin
            n_eff = NW'(MAX_VERTICES);
        end
        else
        begin
            n_eff = vc_ext[NW-1:0];
        end
    end

    lpcc_cmd_t    cmd;
    lpcc_status_t status;

    lpcc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_edge (last_edge),
        .in_stall  (in_stall),
        .status    (status),
        .cmd       (cmd)
    );

    lpcc_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES),
        .NW           (NW)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .n_eff         (n_eff),
        .from_vertex   (from_vertex),
        .to_vertex     (to_vertex),
        .reward        (reward),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .high_score    (high_score),
        .unbounded     (unbounded),
        .edges_dropped (edges_dropped)
    );

endmodule
`default_nettype wire

// ===== test/longest_path_cycle_check_tb.sv =====
// Testbench for longest_path_cycle_check: loads random and directed graphs,
// predicts each high score / unbounded / dropped result and checks it.
// Depends on lpcc_pkg and the longest_path_cycle_check RTL.
`default_nettype none
module longest_path_cycle_check_tb;
    import lpcc_pkg::*;

    localparam int NV = 256;
    localparam int NE = 1024;
    localparam longint INF_DIST = 64'sd5000000000000;
    localparam longint FLOOR_DIST = -(64'sd1 <<< 43);
    localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED = 3'd4;

    typedef struct {
        logic [VERT_W-1:0]          src;
        logic [VERT_W-1:0]          dst;
        logic signed [REWARD_W-1:0] rwd;
    } edge_item_t;

    typedef struct {
        logic signed [DIST_W-1:0] score;
        logic                     unb;
        logic                     drop;
    } score_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [VERT_W-1:0] from_vertex = '0;
    logic [VERT_W-1:0] to_vertex = '0;
    logic signed [REWARD_W-1:0] reward = '0;
    logic last_edge = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [DIST_W-1:0] high_score;
    logic unbounded;
    logic edges_dropped;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    longest_path_cycle_check i_dut (.*);

    // model state
    logic [VERT_W-1:0] cfg_vcount = VERTEX_COUNT_RST;
    logic [VERT_W-1:0] st_src [NE];
    logic [VERT_W-1:0] st_dst [NE];
    longint st_cost [NE];
    int  st_count = 0;
    bit  st_overflow = 0;
    bit  reach [NV];
    longint best_dist [NV];
    score_t pending_scores [$];
    int  fail_count = 0;
    int  burst_left = 0;

    initial begin
        forever #2 clk = ~clk;
    end

    initial begin
        #40000000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic bit vert_ok(logic [VERT_W-1:0] v, int n);
        return v >= 1 && v <= n;
    endfunction

    // fold one accepted edge into the model; on the closing edge solve the graph
    function automatic void predict_edge(edge_item_t e, bit last);
        int n;
        bit changed;
        bit unb;
        longint cand;
        score_t r;
        if (st_count < NE) begin
            st_src[st_count] = e.src;
            st_dst[st_count] = e.dst;
            st_cost[st_count] = -longint'(e.rwd);
            st_count++;
        end else begin
            st_overflow = 1;
        end
        if (!last) return;
        n = cfg_vcount;
        if (n == 0) n = 1;
        if (n > NV) n = NV;
        foreach (reach[v]) begin
            reach[v] = 0;
            best_dist[v] = INF_DIST;
        end
        // backward reachability to the target
        reach[n-1] = 1;
        changed = 1;
        while (changed) begin
            changed = 0;
            for (int k = 0; k < st_count; k++) begin
                if (!vert_ok(st_src[k], n) || !vert_ok(st_dst[k], n)) continue;
                if (reach[st_dst[k]-1] && !reach[st_src[k]-1]) begin
                    reach[st_src[k]-1] = 1;
                    changed = 1;
                end
            end
        end
        // relaxation rounds
        unb = 0;
        best_dist[0] = 0;
        for (int rd = 0; rd < n && !unb; rd++) begin
            for (int k = 0; k < st_count && !unb; k++) begin
                if (!vert_ok(st_src[k], n) || !vert_ok(st_dst[k], n)) continue;
                if (!reach[st_src[k]-1] || !reach[st_dst[k]-1]) continue;
                if (best_dist[st_src[k]-1] == INF_DIST) continue;
                cand = best_dist[st_src[k]-1] + st_cost[k];
                if (cand < best_dist[st_dst[k]-1]) begin
                    if (cand < FLOOR_DIST) unb = 1;
                    else begin
                        best_dist[st_dst[k]-1] = cand;
                        if (rd == n - 1) unb = 1;
                    end
                end
            end
        end
        r.score = unb ? '0 : DIST_W'(-best_dist[n-1]);
        r.unb = unb;
        r.drop = st_overflow;
        pending_scores = {pending_scores, r};
        st_count = 0;
        st_overflow = 0;
    endfunction

    // send one edge item, with bursty gaps
    task automatic send_edge(edge_item_t e, bit last);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        in_valid <= 1'b1;
        from_vertex <= e.src;
        to_vertex <= e.dst;
        reward <= e.rwd;
        last_edge <= last;
        do @(posedge clk); while (in_stall);
        predict_edge(e, last);
    endtask

    task automatic send_graph(edge_item_t g[$]);
        foreach (g[k]) send_edge(g[k], k == g.size() - 1);
    endtask

    // wait until every result is in, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_scores.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_VERTEX_COUNT) cfg_vcount = data[VERT_W-1:0];
    endtask

    task automatic apb_check_read();
        psel <= 1'b1;
        pwrite <= 1'b0;
        penable <= 1'b0;
        paddr <= ADDR_VERTEX_COUNT;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[VERT_W-1:0] !== cfg_vcount) begin
            $display("%0t: vertex_count read expected %0d actual %0d",
                     $time, cfg_vcount, prdata[VERT_W-1:0]);
            fail_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic edge_item_t mk(int s, int d, longint r);
        edge_item_t e;
        e.src = VERT_W'(s);
        e.dst = VERT_W'(d);
        e.rwd = REWARD_W'(r);
        return e;
    endfunction

    // result checker
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_scores.size() == 0) begin
                $display("%0t: unexpected result score %0d", $time, high_score);
                fail_count++;
            end else begin
                score_t x;
                x = pending_scores.pop_front();
                if (high_score !== x.score) begin
                    $display("%0t: high_score expected %0d actual %0d",
                             $time, x.score, high_score);
                    fail_count++;
                end
                if (unbounded !== x.unb) begin
                    $display("%0t: unbounded expected %0b actual %0b",
                             $time, x.unb, unbounded);
                    fail_count++;
                end
                if (edges_dropped !== x.drop) begin
                    $display("%0t: edges_dropped expected %0b actual %0b",
                             $time, x.drop, edges_dropped);
                    fail_count++;
                end
            end
        end
    end

    // receiver stall pattern: light random stalls
    always @(posedge clk) begin
        int mode;
        mode = $urandom_range(0, 2);
        if ($urandom_range(0, 63) == 0) out_stall <= (mode == 2);
        else if (mode == 0) out_stall <= out_stall & ($urandom_range(0, 1) == 1);
        else out_stall <= ($urandom_range(0, 3) == 0);
    end

    task automatic test_extremes();
        edge_item_t g[$];
        // default 256 vertices, single heaviest edge straight to the target
        g = {mk(1, 256, 1073741823)};
        send_graph(g);
        g = {mk(1, 128, -1073741824), mk(128, 256, -5), mk(511, 256, 7), mk(0, 1, 9)};
        send_graph(g);
        drain();
        apb_check_read();
        // zero acts as one vertex: self loop on the target is a positive cycle
        apb_write(ADDR_VERTEX_COUNT, 0);
        send_graph({mk(1, 1, 5)});
        send_graph({mk(1, 1, -5)});
        drain();
        // above range acts as the largest size
        apb_write(ADDR_VERTEX_COUNT, 511);
        send_graph({mk(1, 2, 3), mk(2, 256, 4)});
        drain();
        apb_write(ADDR_UNUSED, 3);
        apb_check_read();
    endtask

    task automatic test_small_graphs();
        drain();
        apb_write(ADDR_VERTEX_COUNT, 4);
        apb_check_read();
        // target unreachable
        send_graph({mk(1, 2, 10), mk(3, 4, 5)});
        // positive cycle on a useful path
        send_graph({mk(1, 2, 1), mk(2, 3, 1), mk(3, 2, 1), mk(3, 4, 1)});
        // positive cycle off the useful path is ignored
        send_graph({mk(1, 4, -3), mk(2, 3, 9), mk(3, 2, 9)});
        // best of two paths, endpoint out of range ignored
        send_graph({mk(1, 2, 100), mk(2, 4, -20), mk(1, 4, 50), mk(5, 4, 999)});
    endtask

    task automatic test_overflow();
        edge_item_t g[$];
        drain();
        apb_write(ADDR_VERTEX_COUNT, 2);
        for (int k = 0; k < NE + 1; k++)
            g = {g, mk(1, 2, $urandom_range(0, 200) - 100)};
        send_graph(g);
        send_graph({mk(1, 2, 77)});
    endtask

    task automatic test_random();
        int sent;
        int n;
        int ne;
        edge_item_t g[$];
        edge_item_t e;
        sent = 0;
        while (sent < 400) begin
            drain();
            case ($urandom_range(0, 9))
                0: n = 256;
                1: n = 1;
                default: n = $urandom_range(2, 10);
            endcase
            apb_write(ADDR_VERTEX_COUNT, n);
            for (int gr = 0; gr < 8; gr++) begin
                g.delete();
                ne = (n == 256) ? $urandom_range(1, 6) : $urandom_range(1, 14);
                for (int k = 0; k < ne; k++) begin
                    if ($urandom_range(0, 15) == 0) begin
                        e.src = VERT_W'($urandom);
                        e.dst = VERT_W'($urandom);
                    end else begin
                        e.src = VERT_W'($urandom_range(1, n));
                        e.dst = VERT_W'($urandom_range(1, n));
                    end
                    if ($urandom_range(0, 7) == 0) e.rwd = REWARD_W'($urandom);
                    else e.rwd = REWARD_W'($urandom_range(0, 2000) - 1000);
                    g = {g, e};
                end
                send_graph(g);
                sent += ne;
                if ($urandom_range(0, 5) == 0) drain();
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_small_graphs();
        test_overflow();
        test_random();
        drain();
        repeat (50) @(posedge clk);
        if (fail_count == 0 && pending_scores.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/lpcc_pkg.sv
rtl/lpcc_ram.sv
rtl/lpcc_ctrl.sv
rtl/lpcc_dp.sv
rtl/longest_path_cycle_check.sv
test/longest_path_cycle_check_tb.sv
